/* hdl/dppd_pkg.sv */
package dppd_pkg;

    localparam int POSITIONS    = 128;
    localparam int DIGIT_VALUES = 16;

    localparam int POS_W = $clog2(POSITIONS);
    localparam int CNT_W = $clog2(POSITIONS + 1);
    localparam int DIG_W = $clog2(DIGIT_VALUES);

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_DRAW  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_RANGE = 2'd2,
        STS_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

endpackage

/* hdl/digit_position_pool_draw.sv */
// Position pool per hex digit. A request is taken when start is high and busy is low, and
// its result appears on position, remaining and status for exactly one cycle with done
// high; the receiver cannot stall, so it must take the result in that cycle. Clear, load,
// the unused action and draws that are refused (empty pool or pick out of range) answer
// in the next cycle and leave busy low, so such requests can follow every cycle.
// An accepted draw scans the loaded positions in ascending order, one position per cycle
// through the single read port of the digit memory into a compare stage; busy stays high
// until the compare finds the pick or passes the last loaded position, and done rises in
// the same cycle that busy falls. There is no clearing pass after reset; the block takes
// requests from the first cycle.
module digit_position_pool_draw (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                action,
    input  logic [3:0]                digit,
    input  logic [6:0]                pick_index,
    output logic                      done,
    output logic [dppd_pkg::POS_W-1:0] position,
    output logic [dppd_pkg::CNT_W-1:0] remaining,
    output logic [1:0]                status
);
    import dppd_pkg::*;

    // digit memory, each entry a taken mark above the digit, and its registered read
    logic [DIG_W:0]   store_mem [POSITIONS];
    logic [DIG_W:0]   rd_entry_reg;
    logic             store_we;
    logic             mem_we;
    logic [POS_W-1:0] mem_waddr;
    logic [DIG_W:0]   mem_wdata;

    // control and bookkeeping state
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg [DIGIT_VALUES];
    logic [CNT_W-1:0]         count_next [DIGIT_VALUES];
    logic [CNT_W-1:0]         load_count_reg, load_count_next;
    logic [CNT_W-1:0]         scan_addr_reg, scan_addr_next;
    logic [POS_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                     cmp_valid_reg, cmp_valid_next;
    logic [6:0]               seen_reg, seen_next;
    logic [6:0]               pick_reg, pick_next;
    logic [DIG_W-1:0]         dig_reg, dig_next;
    logic                     done_reg, done_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    status_t                  sts_reg, sts_next;

    logic                     accept;
    action_t                  act_in;
    logic [DIG_W-1:0]         dig_in;
    logic [CNT_W-1:0]         cur_count;
    logic                     hit;
    logic                     take_hit;
    logic                     last_cmp;

    assign accept  = start && (state_reg == S_IDLE);
    assign act_in  = action_t'(action);
    assign dig_in  = DIG_W'(digit % DIGIT_VALUES);
    assign cur_count = count_reg[dig_in];
    assign store_we  = accept && (act_in == ACT_LOAD) && (load_count_reg < CNT_W'(POSITIONS));

    // compare stage of the scan
    assign hit      = cmp_valid_reg && (rd_entry_reg[DIG_W-1:0] == dig_reg)
                      && !rd_entry_reg[DIG_W];
    assign take_hit = (state_reg == S_SCAN) && hit && (seen_reg == pick_reg);
    assign last_cmp = cmp_valid_reg && ({1'b0, cmp_idx_reg} == CNT_W'(load_count_reg - 1'b1));

    // single write port: a load writes a fresh entry, a draw sets the taken mark
    assign mem_we    = store_we || take_hit;
    assign mem_waddr = store_we ? load_count_reg[POS_W-1:0] : cmp_idx_reg;
    assign mem_wdata = store_we ? {1'b0, dig_in} : {1'b1, dig_reg};

    // memory write and read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rd_entry_reg <= store_mem[scan_addr_reg[POS_W-1:0]];
    end

    // sequencer and next-state logic
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        load_count_next = load_count_reg;
        scan_addr_next  = scan_addr_reg;
        cmp_idx_next    = scan_addr_reg[POS_W-1:0];
        cmp_valid_next  = 1'b0;
        seen_next       = seen_reg;
        pick_next       = pick_reg;
        dig_next        = dig_reg;
        done_next       = 1'b0;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        sts_next        = sts_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    pos_next  = '0;
                    rem_next  = cur_count;
                    sts_next  = STS_OK;
                    dig_next  = dig_in;
                    pick_next = pick_index;
                    unique case (act_in)
                        ACT_CLEAR:
                        begin
                            // taken marks need no clearing, every load writes a fresh entry
                            load_count_next = '0;
                            for (int i = 0; i < DIGIT_VALUES; i++)
                            begin
                                count_next[i] = '0;
                            end
                            rem_next = '0;
                        end
                        ACT_LOAD:
                        begin
                            if (store_we)
                            begin
                                count_next[dig_in] = cur_count + 1'b1;
                                load_count_next    = load_count_reg + 1'b1;
                                pos_next = load_count_reg[POS_W-1:0];
                                rem_next = cur_count + 1'b1;
                            end
                            else
                            begin
                                sts_next = STS_FULL;
                            end
                        end
                        ACT_DRAW:
                        begin
                            priority if (cur_count == '0)
                            begin
                                sts_next = STS_EMPTY;
                            end
                            else if ({1'b0, pick_index} >= cur_count)
                            begin
                                sts_next = STS_RANGE;
                            end
                            else
                            begin
                                // start the scan, result comes from the compare stage
                                done_next      = 1'b0;
                                state_next     = S_SCAN;
                                scan_addr_next = '0;
                                seen_next      = '0;
                            end
                        end
                        ACT_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // issue the next read while the previous digit is compared
                cmp_valid_next = (scan_addr_reg < load_count_reg);
                if (scan_addr_reg < load_count_reg)
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                if (take_hit)
                begin
                    count_next[dig_reg] = count_reg[dig_reg] - 1'b1;
                    state_next     = S_IDLE;
                    cmp_valid_next = 1'b0;
                    done_next      = 1'b1;
                    pos_next       = cmp_idx_reg;
                    rem_next       = count_reg[dig_reg] - 1'b1;
                    sts_next       = STS_OK;
                end
                else if (last_cmp)
                begin
                    // ran out of positions without finding the pick
                    state_next     = S_IDLE;
                    cmp_valid_next = 1'b0;
                    done_next      = 1'b1;
                    pos_next       = '0;
                    rem_next       = count_reg[dig_reg];
                    sts_next       = STS_RANGE;
                end
                else if (hit)
                begin
                    seen_next = seen_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            load_count_reg <= '0;
            cmp_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
            for (int i = 0; i < DIGIT_VALUES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            cmp_valid_reg  <= cmp_valid_next;
            done_reg       <= done_next;
            count_reg      <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        cmp_idx_reg   <= cmp_idx_next;
        seen_reg      <= seen_next;
        pick_reg      <= pick_next;
        dig_reg       <= dig_next;
        pos_reg       <= pos_next;
        rem_reg       <= rem_next;
        sts_reg       <= sts_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign position  = pos_reg;
    assign remaining = rem_reg;
    assign status    = sts_reg;

`ifndef ASSERT_OFF
    // a result never shows while a scan is still running
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe during scan");

    // a load into a table with room answers ok in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_LOAD) && (load_count_reg < CNT_W'(POSITIONS)))
        |=> (done && (status == STS_OK)))
        else $error("load with room not answered ok");

    // the fill count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= CNT_W'(POSITIONS))
        else $error("load count beyond table size");

    // a successful draw ends the scan with an ok result
    assert property (@(posedge clk) disable iff (!rst_n)
        take_hit |=> (done && !busy && (status == STS_OK)))
        else $error("draw did not answer ok");
`endif

endmodule
